>>> hw/rtl/yay0_lz_decompressor_defines.svh
// Assertion macros for the Yay0 decoder. Each use expects clk and rst_n in scope.
`ifndef YAY0_LZ_DECOMPRESSOR_DEFINES_SVH
`define YAY0_LZ_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication.
`define YAY0_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define YAY0_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/yay0_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package yay0_pkg;

    localparam int WIN_AW    = 12;
    localparam int WIN_DEPTH = 1 << WIN_AW;
    localparam int LEN_W     = 9;
    localparam int SIZE_W    = 24;
    localparam int DATA_W    = 64;
    localparam int OCNT_W    = 4;
    localparam int MAX_LANES = DATA_W / 8;

    localparam logic [SIZE_W-1:0] SIZE_MAX       = 24'hFFFFFF;
    localparam logic [LEN_W-1:0]  LONG_LEN_BIAS  = 9'd18;
    localparam logic [LEN_W-1:0]  SHORT_LEN_BIAS = 9'd2;

    typedef logic [7:0]        byte_t;
    typedef logic [WIN_AW-1:0] win_addr_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [SIZE_W-1:0] size_t;

    // control from the sequencer to the history RAM
    typedef struct packed {
        logic      lit_load;
        byte_t     lit_byte;
        logic      issue;
        win_addr_t rd_addr;
        logic      fwd;
        logic      absorb;
        win_addr_t wr_addr;
    } hist_ctl_t;

    // control from the sequencer to the lane packer
    typedef struct packed {
        logic absorb;
        logic flush;
        logic run_last;
        logic done;
    } pack_ctl_t;

    // status from the lane packer
    typedef struct packed {
        logic out_free;
        logic lane_last;
    } pack_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/yay0_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface yay0_tok_if;
    import yay0_pkg::*;

    logic         valid;
    logic         ready;
    logic         is_copy;
    byte_t        literal_byte;
    logic [15:0]  link_code;
    byte_t        count_byte;

    modport source (output valid, is_copy, literal_byte, link_code, count_byte,
                    input ready);
    modport sink   (input valid, is_copy, literal_byte, link_code, count_byte,
                    output ready);
endinterface

interface yay0_res_if;
    import yay0_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] out_data;
    logic [OCNT_W-1:0] out_count;
    logic              run_last;
    logic              done_res;

    modport source (output valid, out_data, out_count, run_last, done_res,
                    input ready);
    modport sink   (input valid, out_data, out_count, run_last, done_res,
                    output ready);
endinterface

interface yay0_cfg_if;
    import yay0_pkg::*;

    logic  valid;
    logic  ready;
    size_t decoded_size;

    modport source (output valid, decoded_size, input ready);
    modport sink   (input valid, decoded_size, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/yay0_hist.sv
`timescale 1ns / 1ps
`default_nettype none

// History window RAM, one read and one write per cycle, plus byte source select.
module yay0_hist (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire yay0_pkg::hist_ctl_t ctl,
    output yay0_pkg::byte_t        byte_out
);
    import yay0_pkg::*;

    byte_t mem [WIN_DEPTH];
    byte_t rd_data_reg;
    byte_t lit_byte_reg;
    byte_t last_byte_reg;
    logic  lit_sel_reg;
    logic  fwd_reg;

    // forwarded byte covers the distance-one read of the byte being written
    assign byte_out = lit_sel_reg ? lit_byte_reg :
                      (fwd_reg ? last_byte_reg : rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.absorb)
        begin
            mem[ctl.wr_addr] <= byte_out;
        end
        if (ctl.issue)
        begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_sel_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            lit_byte_reg  <= '0;
            last_byte_reg <= '0;
        end
        else
        begin
            if (ctl.lit_load)
            begin
                lit_sel_reg  <= 1'b1;
                lit_byte_reg <= ctl.lit_byte;
            end
            else if (ctl.issue)
            begin
                lit_sel_reg <= 1'b0;
            end
            if (ctl.issue)
            begin
                fwd_reg <= ctl.fwd;
            end
            if (ctl.absorb)
            begin
                last_byte_reg <= byte_out;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/yay0_pack.sv
`timescale 1ns / 1ps
`default_nettype none

// Gathers bytes into lanes and holds the result beat until it is taken.
module yay0_pack #(
    parameter int OUT_LANES = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire yay0_pkg::pack_ctl_t ctl,
    input  wire yay0_pkg::byte_t     byte_in,
    output yay0_pkg::pack_stat_t     stat,
    yay0_res_if.source               res
);
    import yay0_pkg::*;

    localparam int CNT_W = $clog2(OUT_LANES + 1);

    logic [DATA_W-1:0] acc_data_reg;
    logic [CNT_W-1:0]  acc_cnt_reg;
    logic [DATA_W-1:0] merged;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [OCNT_W-1:0] out_count_reg;
    logic              run_last_reg;
    logic              done_reg;

    assign stat.out_free  = !out_valid_reg || res.ready;
    assign stat.lane_last = (acc_cnt_reg == CNT_W'(OUT_LANES - 1));

    always_comb
    begin
        merged = '0;
        for (int l = 0; l < OUT_LANES; l++)
        begin
            merged[8*l +: 8] = (acc_cnt_reg == CNT_W'(l)) ? byte_in
                                                           : acc_data_reg[8*l +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_data_reg  <= '0;
            acc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_count_reg <= '0;
            run_last_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            priority if (ctl.absorb && ctl.flush)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= merged;
                out_count_reg <= OCNT_W'(acc_cnt_reg) + OCNT_W'(1);
                run_last_reg  <= ctl.run_last;
                done_reg      <= ctl.done;
                acc_data_reg  <= '0;
                acc_cnt_reg   <= '0;
            end
            else if (ctl.absorb)
            begin
                acc_data_reg <= merged;
                acc_cnt_reg  <= acc_cnt_reg + CNT_W'(1);
                if (res.ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_data  = out_data_reg;
    assign res.out_count = out_count_reg;
    assign res.run_last  = run_last_reg;
    assign res.done_res  = done_reg;

endmodule

`default_nettype wire

>>> hw/rtl/yay0_lz_decompressor.sv
// A literal is registered in the history block, then placed in a lane and its beat registered.
// A copy's bytes are read from the 4096-byte history RAM and placed in lanes, a byte a
// cycle while a byte that closes a beat finds room in the output register. Tokens are
// taken one at a time; the byte rate is set by the single read and single write port.
// A result beat may wait in the output register while the next token is accepted.
// Reset (rst_n, async, active low) clears counters, write position, decoded_size and
// all handshake state; the history RAM is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "yay0_lz_decompressor_defines.svh"

module yay0_lz_decompressor #(
    parameter int OUT_LANES = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    yay0_tok_if.sink    tok,
    yay0_res_if.source  res,
    yay0_cfg_if.sink    cfg
);
    import yay0_pkg::*;

    // ------------------------------------------------------------------
    // Sequencer state
    //   absorb_left_reg : bytes of the current token not yet placed in a lane
    //   issue_left_reg  : bytes of the current copy not yet read from history
    //   rd_valid_reg    : a byte (RAM read or literal) waits at the hist output
    //   rd_pos_reg      : write position of the byte for the next read
    //   off_reg         : distance minus one of the current copy
    // ------------------------------------------------------------------
    size_t      decoded_size_reg;
    size_t      produced_reg;
    win_addr_t  wr_pos_reg;
    len_t       absorb_left_reg;
    len_t       issue_left_reg;
    logic       rd_valid_reg;
    win_addr_t  rd_pos_reg;
    win_addr_t  off_reg;

    hist_ctl_t  hctl;
    pack_ctl_t  pctl;
    pack_stat_t pstat;
    byte_t      hist_byte;

    logic       stream_done;
    logic       tok_fire;
    logic [3:0] len_nib;
    len_t       len_dec;
    logic       group_end;
    logic       absorb;
    logic       issue;
    win_addr_t  rd_addr;
    size_t      produced_inc;

    // config is taken at any time; the user writes it only while idle
    assign cfg.ready = 1'b1;

    // a new token waits until every byte of the last one sits in a lane
    assign tok.ready = (absorb_left_reg == '0);

    always_comb
    begin
        stream_done = (produced_reg >= decoded_size_reg);
        tok_fire    = tok.valid && tok.ready;

        len_nib = tok.link_code[15:12];
        len_dec = (len_nib == 4'd0) ? (LEN_W'(tok.count_byte) + LONG_LEN_BIAS)
                                    : (LEN_W'(len_nib) + SHORT_LEN_BIAS);

        // a byte that closes a beat needs room in the output register
        group_end = pstat.lane_last || (absorb_left_reg == LEN_W'(1));
        absorb    = rd_valid_reg && (!group_end || pstat.out_free);

        // read the next source byte when the hist output is free or drains now
        issue   = (issue_left_reg != '0) && (!rd_valid_reg || absorb);
        rd_addr = rd_pos_reg + ~off_reg;   // pos - (off + 1), mod window

        produced_inc = (produced_reg == SIZE_MAX) ? produced_reg
                                                  : produced_reg + SIZE_W'(1);

        hctl.lit_load = tok_fire && !stream_done && !tok.is_copy;
        hctl.lit_byte = tok.literal_byte;
        hctl.issue    = issue;
        hctl.rd_addr  = rd_addr;
        // distance one: the source byte is the one written this cycle
        hctl.fwd      = absorb && (rd_addr == wr_pos_reg);
        hctl.absorb   = absorb;
        hctl.wr_addr  = wr_pos_reg;

        pctl.absorb   = absorb;
        pctl.flush    = group_end;
        pctl.run_last = (absorb_left_reg == LEN_W'(1));
        pctl.done     = (produced_inc >= decoded_size_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decoded_size_reg <= '0;
            produced_reg     <= '0;
            wr_pos_reg       <= '0;
            absorb_left_reg  <= '0;
            issue_left_reg   <= '0;
            rd_valid_reg     <= 1'b0;
            rd_pos_reg       <= '0;
            off_reg          <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                decoded_size_reg <= cfg.decoded_size;
            end

            priority if (tok_fire && !stream_done)
            begin
                if (tok.is_copy)
                begin
                    absorb_left_reg <= len_dec;
                    issue_left_reg  <= len_dec;
                    off_reg         <= tok.link_code[WIN_AW-1:0];
                    rd_pos_reg      <= wr_pos_reg;
                    rd_valid_reg    <= 1'b0;
                end
                else
                begin
                    absorb_left_reg <= LEN_W'(1);
                    issue_left_reg  <= '0;
                    rd_valid_reg    <= 1'b1;
                end
            end
            else
            begin
                if (absorb)
                begin
                    absorb_left_reg <= absorb_left_reg - LEN_W'(1);
                    wr_pos_reg      <= wr_pos_reg + WIN_AW'(1);
                    produced_reg    <= produced_inc;
                end
                if (issue)
                begin
                    issue_left_reg <= issue_left_reg - LEN_W'(1);
                    rd_pos_reg     <= rd_pos_reg + WIN_AW'(1);
                    rd_valid_reg   <= 1'b1;
                end
                else if (absorb)
                begin
                    rd_valid_reg <= 1'b0;
                end
            end
        end
    end

    yay0_hist u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (hctl),
        .byte_out (hist_byte)
    );

    yay0_pack #(
        .OUT_LANES (OUT_LANES)
    ) u_pack (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (pctl),
        .byte_in (hist_byte),
        .stat    (pstat),
        .res     (res)
    );

    // reads never run ahead of lane placement by more than the token holds
    `YAY0_ASSERT(a_issue_bound, 1'b1, issue_left_reg <= absorb_left_reg, "issue ahead of absorb")
    // forwarding only happens on distance-one copies
    `YAY0_ASSERT(a_fwd_dist1, hctl.fwd && hctl.issue, off_reg == '0, "forward at distance > 1")
    // produced byte count never goes backward
    `YAY0_ASSERT_NEXT(a_prod_mono, 1'b1, produced_reg >= $past(produced_reg), "produced decreased")
    // an output beat holds between one and OUT_LANES bytes
    `YAY0_ASSERT(a_out_count, res.valid,
        res.out_count != '0 && res.out_count <= OCNT_W'(OUT_LANES), "bad out_count")
    // an idle sequencer has no byte waiting at the history output
    `YAY0_ASSERT(a_idle_empty, tok.ready, !rd_valid_reg && issue_left_reg == '0, "idle with work")

endmodule

`default_nettype wire
